[rtl/core/sts_pkg.sv]
// Shared types and constants for the servo target supervisor.
// Item layouts, register indexes and field widths; no dependencies.
package sts_pkg;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int RAW_W       = 12;
    localparam int SCALE_W     = 24;
    localparam int DELAY_W     = 16;
    localparam int FRAC_BITS   = 24;

    localparam logic [RAW_W-1:0]   CENTER_RESET    = 12'd2048;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd256000;
    localparam logic [RAW_W-1:0]   TOLERANCE_RESET = 12'd20;
    localparam logic [DELAY_W-1:0] DELAY_RESET     = 16'd500;
    localparam logic [RAW_W-1:0]   RAW_MAX         = 12'd4095;

    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY     = 2'd3;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_ACK  = 1'b1
    } kind_t;

    typedef struct packed {
        logic               write_ok;
        logic               servo_online;
        logic               servo_moving;
        logic [RAW_W-1:0]   feedback_raw;
        logic signed [31:0] command_target;
        logic [31:0]        command_sequence;
        logic               command_valid;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       pad;
        logic [31:0]      recovery_total;
        logic [31:0]      error_total;
        logic             recovery_fired;
        logic [RAW_W-1:0] position_raw;
        logic             send_position;
    } out_item_t;

endpackage

[rtl/core/sts_raw_conv.sv]
// Target conversion from signed Q16.16 metres to a clamped raw servo position.
// Depends on sts_pkg for widths and the raw limit.
module sts_raw_conv (
    input  logic signed [31:0]               target_q16,
    input  logic [sts_pkg::SCALE_W-1:0]      scale_q8,
    input  logic [sts_pkg::RAW_W-1:0]        centre_pos,
    output logic [sts_pkg::RAW_W-1:0]        raw
);
    import sts_pkg::*;

    logic signed [56:0] prod;
    logic signed [57:0] center_ext;
    logic signed [57:0] diff;
    logic [33:0]        quot;

    assign prod       = target_q16 * $signed({1'b0, scale_q8});
    assign center_ext = $signed({22'b0, centre_pos, 24'b0});
    assign diff       = center_ext - $signed({prod[56], prod});
    assign quot       = diff[57:FRAC_BITS];

    always_comb begin
        if (diff[57]) begin
            raw = '0;
        end else if (|quot[33:RAW_W]) begin
            raw = RAW_MAX;
        end else begin
            raw = quot[RAW_W-1:0];
        end
    end

endmodule

[rtl/core/servo_target_supervisor.sv]
// Servo target supervisor top level: input register, decision logic, result register.
// Depends on sts_pkg and sts_raw_conv.

// One request in, one result out. A request is taken every cycle when the result side
// keeps up, so throughput is one request per cycle; its result passes from the input
// register through the state update, with the 32x24 target scaling multiplier, to the
// result register on m_tdata. Configuration writes are taken at once (cfg_ready
// is always high) and must only be issued while no request is in flight.
module servo_target_supervisor (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg_data holds the register value in its low bits
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: now_ms, command_valid, command_sequence, command_target,
    //          feedback_raw, servo_moving, servo_online, write_ok
    input  logic [sts_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: kind
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: send_position, position_raw, recovery_fired, error_total,
    //          recovery_total, two zero bits
    output logic [sts_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import sts_pkg::*;

    logic [RAW_W-1:0]   center_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [RAW_W-1:0]   tolerance_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    kind_t     in_kind_reg;
    logic      m_valid_reg;
    out_item_t res_reg;

    logic [RAW_W-1:0] target_store_reg, target_store_next;
    logic [31:0]      last_seq_reg, last_seq_next;
    logic [31:0]      applied_time_reg, applied_time_next;
    logic             received_reg, received_next;
    logic             applied_reg, applied_next;
    logic             recovery_done_reg, recovery_done_next;
    logic             awaiting_reg, awaiting_next;
    logic [31:0]      error_count_reg, error_count_next;
    logic [31:0]      recovery_count_reg, recovery_count_next;

    logic             advance;
    logic             proc;
    logic [RAW_W-1:0] conv_raw;
    logic             send;
    logic             fired;
    logic [RAW_W-1:0] pos_err;
    logic [31:0]      elapsed;
    out_item_t        res_next;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = res_reg;

    sts_raw_conv u_conv (
        .target_q16 (in_item_reg.command_target),
        .scale_q8   (scale_reg),
        .centre_pos (center_reg),
        .raw        (conv_raw)
    );

    always_comb begin
        target_store_next   = target_store_reg;
        last_seq_next       = last_seq_reg;
        applied_time_next   = applied_time_reg;
        received_next       = received_reg;
        applied_next        = applied_reg;
        recovery_done_next  = recovery_done_reg;
        awaiting_next       = awaiting_reg;
        error_count_next    = error_count_reg;
        recovery_count_next = recovery_count_reg;
        send                = 1'b0;
        fired               = 1'b0;
        pos_err             = '0;
        elapsed             = in_item_reg.now_ms - applied_time_reg;

        if (in_kind_reg == KIND_ACK) begin
            if (awaiting_reg) begin
                awaiting_next = 1'b0;
                if (in_item_reg.write_ok) begin
                    applied_next      = 1'b1;
                    applied_time_next = in_item_reg.now_ms;
                end else begin
                    error_count_next = error_count_reg + 32'd1;
                    applied_next     = 1'b0;
                end
            end
        end else if (!awaiting_reg) begin
            if (in_item_reg.command_valid &&
                in_item_reg.command_sequence != last_seq_reg) begin
                last_seq_next = in_item_reg.command_sequence;
                if (!received_reg || conv_raw != target_store_reg) begin
                    target_store_next  = conv_raw;
                    applied_next       = 1'b0;
                    recovery_done_next = 1'b0;
                end
                received_next = 1'b1;
            end
            if (received_next) begin
                send = 1'b1;
                if (applied_next && in_item_reg.servo_online) begin
                    pos_err = (target_store_next >= in_item_reg.feedback_raw)
                            ? target_store_next - in_item_reg.feedback_raw
                            : in_item_reg.feedback_raw - target_store_next;
                    if (!recovery_done_next && !in_item_reg.servo_moving &&
                        pos_err > tolerance_reg &&
                        elapsed >= {16'b0, delay_reg}) begin
                        recovery_done_next  = 1'b1;
                        recovery_count_next = recovery_count_reg + 32'd1;
                        applied_next        = 1'b0;
                        fired               = 1'b1;
                    end else begin
                        send = 1'b0;
                    end
                end
                if (send) begin
                    awaiting_next = 1'b1;
                end
            end
        end

        res_next.pad            = '0;
        res_next.send_position  = send;
        res_next.position_raw   = send ? target_store_next : '0;
        res_next.recovery_fired = fired;
        res_next.error_total    = error_count_next;
        res_next.recovery_total = recovery_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= CENTER_RESET;
            scale_reg     <= SCALE_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            delay_reg     <= DELAY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER:    center_reg    <= cfg_data[RAW_W-1:0];
                CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_TOLERANCE: tolerance_reg <= cfg_data[RAW_W-1:0];
                CFG_DELAY:     delay_reg     <= cfg_data[DELAY_W-1:0];
                default:       center_reg    <= center_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata);
            in_kind_reg <= kind_t'(s_tuser);
        end
        if (proc) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_store_reg   <= CENTER_RESET;
            last_seq_reg       <= '0;
            applied_time_reg   <= '0;
            received_reg       <= 1'b0;
            applied_reg        <= 1'b0;
            recovery_done_reg  <= 1'b0;
            awaiting_reg       <= 1'b0;
            error_count_reg    <= '0;
            recovery_count_reg <= '0;
        end else if (proc) begin
            target_store_reg   <= target_store_next;
            last_seq_reg       <= last_seq_next;
            applied_time_reg   <= applied_time_next;
            received_reg       <= received_next;
            applied_reg        <= applied_next;
            recovery_done_reg  <= recovery_done_next;
            awaiting_reg       <= awaiting_next;
            error_count_reg    <= error_count_next;
            recovery_count_reg <= recovery_count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_send_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_kind_reg == KIND_TICK && awaiting_reg) |=> !res_reg.send_position)
        else $error("request sent while acknowledgement pending");

    a_fire_implies_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.recovery_fired) |-> res_reg.send_position)
        else $error("recovery fired without a position write");

    a_fire_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && fired) |=> recovery_count_reg == $past(recovery_count_reg) + 32'd1)
        else $error("recovery counter not advanced on recovery");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_send_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && send) |=> awaiting_reg)
        else $error("position write issued without pending acknowledgement");
`endif

endmodule

[sim/servo_target_supervisor_tb.sv]
// Self-checking bench for servo_target_supervisor: a directed table, then random
// requests over several register settings; each decision is checked against the
// table or an in-bench model. Depends on sts_pkg and the supervisor RTL.
module servo_target_supervisor_tb;
    import sts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 254;
    localparam int ROWS        = 25;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] now;
        logic        vld;
        logic [31:0] seq;
        logic [31:0] tgt;
        logic [11:0] fb;
        logic        mov;
        logic        onl;
        logic        ok;
        logic        typed;
        logic        snd;
        logic [11:0] pos;
        logic        fire;
        logic [31:0] errs;
        logic [31:0] recs;
    } stim_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [RAW_W-1:0]   center_q = CENTER_RESET;
    logic [SCALE_W-1:0] scale_q  = SCALE_RESET;
    logic [RAW_W-1:0]   tol_q    = TOLERANCE_RESET;
    logic [DELAY_W-1:0] delay_q  = DELAY_RESET;

    logic [RAW_W-1:0] held_raw    = CENTER_RESET;
    logic [31:0]      seq_taken   = '0;
    logic [31:0]      applied_at  = '0;
    logic             have_cmd    = 1'b0;
    logic             applied     = 1'b0;
    logic             recovered   = 1'b0;
    logic             ack_due     = 1'b0;
    logic [31:0]      fail_writes = '0;
    logic [31:0]      recoveries  = '0;

    out_item_t due_decisions[$];
    out_item_t seen_dec;
    out_item_t due_dec;

    int          requests_sent  = 0;
    int          decisions_seen = 0;
    int          writes_seen    = 0;
    int          fires_seen     = 0;
    int          mismatches     = 0;
    int          quiet          = 0;
    int          burst_left     = 0;
    logic [31:0] clock_ms       = '0;
    logic [31:0] host_seq       = 32'd100;
    logic [31:0] host_tgt       = '0;
    logic [6:0]  stall_cnt      = '0;
    logic [1:0]  stall_mode     = '0;

    servo_target_supervisor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [RAW_W-1:0] metres_to_raw(logic [31:0] tgt);
        longint t;
        longint s;
        longint diff;
        t = $signed(tgt);
        s = scale_q;
        diff = center_q;
        diff = (diff <<< FRAC_BITS) - t * s;
        if (diff < 0)
            return '0;
        diff = diff >>> FRAC_BITS;
        if (diff > RAW_MAX)
            return RAW_MAX;
        return diff[RAW_W-1:0];
    endfunction

    task automatic supervise(kind_t k, in_item_t r, output out_item_t o);
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] err;
        logic [31:0]      elapsed;
        logic             send;
        logic             fired;
        send = 1'b0;
        fired = 1'b0;
        if (k == KIND_ACK) begin
            if (ack_due) begin
                ack_due = 1'b0;
                if (r.write_ok) begin
                    applied = 1'b1;
                    applied_at = r.now_ms;
                end else begin
                    fail_writes = fail_writes + 1;
                    applied = 1'b0;
                end
            end
        end else if (!ack_due) begin
            if (r.command_valid && r.command_sequence != seq_taken) begin
                raw = metres_to_raw(r.command_target);
                seq_taken = r.command_sequence;
                if (!have_cmd || raw != held_raw) begin
                    held_raw = raw;
                    applied = 1'b0;
                    recovered = 1'b0;
                end
                have_cmd = 1'b1;
            end
            if (have_cmd) begin
                send = 1'b1;
                if (applied && r.servo_online) begin
                    err = (held_raw >= r.feedback_raw) ? held_raw - r.feedback_raw
                                                       : r.feedback_raw - held_raw;
                    elapsed = r.now_ms - applied_at;
                    if (!recovered && !r.servo_moving && err > tol_q && elapsed >= delay_q) begin
                        recovered = 1'b1;
                        recoveries = recoveries + 1;
                        applied = 1'b0;
                        fired = 1'b1;
                    end else begin
                        send = 1'b0;
                    end
                end
                if (send)
                    ack_due = 1'b1;
            end
        end
        o = '0;
        o.send_position  = send;
        o.position_raw   = send ? held_raw : '0;
        o.recovery_fired = fired;
        o.error_total    = fail_writes;
        o.recovery_total = recoveries;
    endtask

    task automatic push_request(kind_t k, in_item_t r, logic typed, out_item_t want);
        out_item_t predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        supervise(k, r, predicted);
        due_decisions.push_back(typed ? want : predicted);
        burst_left--;
        requests_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_decisions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CENTER:    center_q = val[RAW_W-1:0];
            CFG_SCALE:     scale_q  = val[SCALE_W-1:0];
            CFG_TOLERANCE: tol_q    = val[RAW_W-1:0];
            CFG_DELAY:     delay_q  = val[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int phase);
        logic [RAW_W-1:0]   c;
        logic [SCALE_W-1:0] s;
        logic [RAW_W-1:0]   t;
        logic [DELAY_W-1:0] d;
        case (phase)
            0: begin
                c = '0;
                s = 1;
                t = '0;
                d = '0;
            end
            1: begin
                c = RAW_MAX;
                s = '1;
                t = RAW_MAX;
                d = '1;
            end
            2: begin
                c = CENTER_RESET;
                s = SCALE_RESET;
                t = TOLERANCE_RESET;
                d = DELAY_RESET;
            end
            default: begin
                c = $urandom_range(0, 4095);
                s = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 1 << 20)
                                                : $urandom_range(1, 24'hFFFFFF);
                t = $urandom_range(0, 64);
                d = $urandom_range(0, 3000);
            end
        endcase
        write_reg(CFG_CENTER, c);
        write_reg(CFG_SCALE, s);
        write_reg(CFG_TOLERANCE, t);
        write_reg(CFG_DELAY, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic next_request(output kind_t k, output in_item_t r);
        int off;
        int fbv;
        clock_ms = ($urandom_range(0, 49) == 0) ? $urandom : clock_ms + $urandom_range(0, 400);
        if ($urandom_range(0, 4) == 0) begin
            host_seq = ($urandom_range(0, 3) == 0) ? $urandom : host_seq + 1;
            case ($urandom_range(0, 5))
                0: host_tgt = $urandom;
                1: host_tgt = '0;
                2: host_tgt = ($urandom_range(0, 1) == 1) ? 32'h7FFFFFFF : 32'h80000000;
                3: host_tgt = 32'($urandom_range(0, 1 << 13)) - 32'(1 << 12);
                4: ;
                default: host_tgt = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
            endcase
        end
        if (ack_due)
            k = ($urandom_range(0, 6) == 0) ? KIND_TICK : KIND_ACK;
        else
            k = ($urandom_range(0, 9) == 0) ? KIND_ACK : KIND_TICK;
        off = int'($urandom_range(0, 2 * tol_q + 4)) - int'(tol_q) - 2;
        fbv = ($urandom_range(0, 1) == 1) ? int'(held_raw) + off : int'($urandom_range(0, 4095));
        if (fbv < 0)
            fbv = 0;
        else if (fbv > 4095)
            fbv = 4095;
        r.now_ms           = clock_ms;
        r.command_valid    = ($urandom_range(0, 9) != 0);
        r.command_sequence = host_seq;
        r.command_target   = host_tgt;
        r.feedback_raw     = fbv[RAW_W-1:0];
        r.servo_moving     = ($urandom_range(0, 3) == 0);
        r.servo_online     = ($urandom_range(0, 7) != 0);
        r.write_ok         = ($urandom_range(0, 4) != 0);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1'b1;
        if (stall_cnt == '1)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 1) == 1);
            2'd2: m_tready <= (stall_cnt[2:0] != 3'd0);
            default: m_tready <= (stall_cnt[3:0] >= 4'd12);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_dec = m_tdata;
            if (due_decisions.size() == 0) begin
                mismatches++;
                $error("result with no request outstanding: %h", m_tdata);
            end else begin
                due_dec = due_decisions.pop_front();
                check_field("send_position", due_dec.send_position, seen_dec.send_position);
                check_field("position_raw", due_dec.position_raw, seen_dec.position_raw);
                check_field("recovery_fired", due_dec.recovery_fired, seen_dec.recovery_fired);
                check_field("error_total", due_dec.error_total, seen_dec.error_total);
                check_field("recovery_total", due_dec.recovery_total, seen_dec.recovery_total);
                decisions_seen++;
                if (seen_dec.send_position)
                    writes_seen++;
                if (seen_dec.recovery_fired)
                    fires_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("servo_target_supervisor_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t plan [ROWS];
        kind_t     k;
        in_item_t  r;
        out_item_t want;
        int        phase_cnt;
        logic      held_off;

        // kind, now, vld, seq, tgt, fb, mov, onl, ok | typed, snd, pos, fire, errs, recs
        plan = '{
            '{KIND_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
            '{KIND_ACK, 5, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
            '{KIND_TICK, 10, 1, 0, 32'h00010000, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
            '{KIND_TICK, 20, 1, 1, 0, 2048, 0, 1, 0, 1, 1, 2048, 0, 0, 0},
            '{KIND_TICK, 30, 1, 2, 32'h00010000, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
            '{KIND_ACK, 40, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 50, 1, 1, 0, 2048, 0, 1, 0, 1, 1, 2048, 0, 1, 0},
            '{KIND_ACK, 1000, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 1100, 1, 1, 0, 2048, 0, 1, 0, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 1200, 1, 1, 0, 2048, 0, 0, 0, 1, 1, 2048, 0, 1, 0},
            '{KIND_ACK, 2000, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 2100, 1, 1, 0, 0, 1, 1, 0, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 2499, 1, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0},
            '{KIND_TICK, 2500, 1, 1, 0, 0, 0, 1, 0, 1, 1, 2048, 1, 1, 1},
            '{KIND_ACK, 2600, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 1},
            '{KIND_TICK, 9000, 1, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 1},
            '{KIND_TICK, 9100, 1, 2, 32'h7FFFFFFF, 0, 0, 1, 0, 1, 1, 0, 0, 1, 1},
            '{KIND_ACK, 9200, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 1},
            '{KIND_TICK, 9300, 1, 3, 32'h80000000, 0, 0, 1, 0, 1, 1, 4095, 0, 1, 1},
            '{KIND_ACK, 9400, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 2, 1},
            '{KIND_TICK, 9500, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 0, 1, 1, 2048, 0, 2, 1},
            '{KIND_ACK, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 4095, 1, 1, 1,
              1, 0, 0, 0, 2, 1},
            '{KIND_TICK, 499, 1, 32'hFFFFFFFF, 0, 4095, 0, 1, 0, 1, 1, 2048, 1, 2, 2},
            '{KIND_ACK, 600, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 3, 2},
            '{KIND_TICK, 700, 1, 5, 32'h00008000, 4095, 1, 0, 0, 0, 0, 0, 0, 0, 0}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            r.now_ms           = plan[i].now;
            r.command_valid    = plan[i].vld;
            r.command_sequence = plan[i].seq;
            r.command_target   = plan[i].tgt;
            r.feedback_raw     = plan[i].fb;
            r.servo_moving     = plan[i].mov;
            r.servo_online     = plan[i].onl;
            r.write_ok         = plan[i].ok;
            want = '0;
            want.send_position  = plan[i].snd;
            want.position_raw   = plan[i].pos;
            want.recovery_fired = plan[i].fire;
            want.error_total    = plan[i].errs;
            want.recovery_total = plan[i].recs;
            push_request(plan[i].kind, r, plan[i].typed, want);
        end
        settle();

        held_off = 1'b0;
        for (int phase = 0; phase < PHASES; phase++) begin
            apply_setting(phase);
            phase_cnt = 0;
            while (phase_cnt < PHASE_ITEMS) begin
                if (phase == 3 && phase_cnt == 120 && !held_off) begin
                    held_off = 1'b1;
                    settle();
                end
                next_request(k, r);
                phase_cnt++;
                push_request(k, r, 1'b0, '0);
            end
            settle();
        end

        $display("%0d requests over %0d register settings, %0d decisions checked",
                 requests_sent, PHASES + 1, decisions_seen);
        $display("%0d position writes and %0d stall recoveries seen, %0d mismatches",
                 writes_seen, fires_seen, mismatches);
        if (mismatches == 0)
            $display("servo_target_supervisor_tb: clean");
        else
            $display("servo_target_supervisor_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sts_pkg.sv
rtl/core/sts_raw_conv.sv
rtl/core/servo_target_supervisor.sv
sim/servo_target_supervisor_tb.sv
